/* src/record_sort_by_id_then_time_macros.svh */
// ----------------------------------------------------------------------------
// Record sort assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during rst.
// ----------------------------------------------------------------------------
`ifndef RECORD_SORT_BY_ID_THEN_TIME_MACROS_SVH
`define RECORD_SORT_BY_ID_THEN_TIME_MACROS_SVH

// Same-cycle implication.
`define RSIT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rsit_pkg.sv */
// ----------------------------------------------------------------------------
// Record sort package
// Store geometry, record layout and action codes for the record sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsit_pkg;

  localparam int DEPTH   = 512;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int TIME_W  = 17;
  localparam int ENTRY_W = ID_W + TIME_W + 1;
  localparam int KEY_W   = ID_W + TIME_W;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // id on top, then time, direction in bit 0; dropping bit 0 gives the key
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tod;
    logic              dir;
  } record_t;

endpackage

`default_nettype wire

/* src/rsit_ram.sv */
// ----------------------------------------------------------------------------
// Record sort RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsit_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 34
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/record_sort_by_id_then_time.sv */
// Load: a single accept step when no unread record is held; otherwise an accept
//   step, then a compare step for each record examined, then a write step if the walk
//   reaches the read position. The single RAM port pair sets this pace.
// Drain: RAM read, then output load; the output load waits while out_stall holds.
// Reset clears counts, overflow flag and output valid; RAM needs no clearing.
// ----------------------------------------------------------------------------
// Record sort by id then time
// Insertion-sorting record store. A load walks down from the tail one RAM
// entry per cycle, moving larger keys up one slot, then drops the new record
// into the gap. Equal keys stay in arrival order. A drain returns the next
// record in order and flags the final one; after it the store is empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "record_sort_by_id_then_time_macros.svh"

module record_sort_by_id_then_time (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [15:0] employee_id,
  input  wire logic [16:0] time_of_day,
  input  wire logic        direction,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             valid_res,
  output logic [15:0]      sorted_id,
  output logic [16:0]      sorted_time,
  output logic             sorted_direction,
  output logic             last_record,
  output logic             overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_DRN_OUT
  } state_t;

  state_t state;

  // Control state
  logic [rsit_pkg::CNT_W-1:0] count;   // records held, emitted ones included
  logic [rsit_pkg::CNT_W-1:0] rp;      // records already emitted
  logic [rsit_pkg::CNT_W-1:0] pos;     // current gap of the insertion walk
  logic                       ovf_seen;
  logic                       hit;     // pending drain has a record to return

  // Payload held for the insertion walk
  rsit_pkg::record_t entry;

  // RAM port
  logic                        wr_en;
  logic [rsit_pkg::ADDR_W-1:0] wr_addr;
  rsit_pkg::record_t           wr_data;
  logic                        rd_en;
  logic [rsit_pkg::ADDR_W-1:0] rd_addr;
  logic [rsit_pkg::ENTRY_W-1:0] rd_raw;
  rsit_pkg::record_t           rd_rec;

  logic                       in_accept;
  logic                       out_free;
  logic                       greater;
  logic [rsit_pkg::CNT_W-1:0] pos_dec;
  logic [rsit_pkg::CNT_W-1:0] pos_dec2;
  logic [rsit_pkg::CNT_W-1:0] cnt_dec;
  logic [rsit_pkg::CNT_W-1:0] rp_inc;
  logic [rsit_pkg::CNT_W-1:0] cnt_inc;
  rsit_pkg::record_t          new_rec;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign new_rec  = '{id: employee_id, tod: time_of_day, dir: direction};
  assign rd_rec   = rsit_pkg::record_t'(rd_raw);
  assign greater  = rd_raw[rsit_pkg::ENTRY_W-1:1] > entry[rsit_pkg::ENTRY_W-1:1];
  assign pos_dec  = pos - rsit_pkg::CNT_W'(1);
  assign pos_dec2 = pos - rsit_pkg::CNT_W'(2);
  assign cnt_dec  = count - rsit_pkg::CNT_W'(1);
  assign cnt_inc  = count + rsit_pkg::CNT_W'(1);
  assign rp_inc   = rp + rsit_pkg::CNT_W'(1);

  // RAM port steering: one read and one write per cycle at most
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = entry;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && action == rsit_pkg::ACT_LOAD && count != rsit_pkg::DEPTH_CNT) begin
          if (count > rp) begin
            // fetch the tail record to start the walk
            rd_en   = 1'b1;
            rd_addr = cnt_dec[rsit_pkg::ADDR_W-1:0];
          end else begin
            // nothing unread: append directly
            wr_en   = 1'b1;
            wr_addr = count[rsit_pkg::ADDR_W-1:0];
            wr_data = new_rec;
          end
        end else if (in_accept && action == rsit_pkg::ACT_DRAIN && rp < count) begin
          rd_en   = 1'b1;
          rd_addr = rp[rsit_pkg::ADDR_W-1:0];
        end
      end
      ST_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = pos[rsit_pkg::ADDR_W-1:0];
        if (greater) begin
          // move the larger record up one slot, fetch the next one down
          wr_data = rd_rec;
          if (pos_dec > rp) begin
            rd_en   = 1'b1;
            rd_addr = pos_dec2[rsit_pkg::ADDR_W-1:0];
          end
        end else begin
          wr_data = entry;
        end
      end
      ST_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos[rsit_pkg::ADDR_W-1:0];
        wr_data = entry;
      end
      ST_DRN_OUT: begin
      end
      default: begin
      end
    endcase
  end

  rsit_ram #(
    .DEPTH (rsit_pkg::DEPTH),
    .WIDTH (rsit_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rp        <= '0;
      pos       <= '0;
      ovf_seen  <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the output beat once taken, unless a new one loads right now
      if (out_valid && !out_stall && state != ST_DRN_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (action == rsit_pkg::ACT_LOAD) begin
              if (count == rsit_pkg::DEPTH_CNT) begin
                ovf_seen <= 1'b1;              // store full: drop the record
              end else if (count > rp) begin
                entry <= new_rec;
                pos   <= count;
                state <= ST_INS_CMP;
              end else begin
                count <= cnt_inc;
              end
            end else begin
              hit   <= (rp < count);
              state <= ST_DRN_OUT;
            end
          end
        end
        ST_INS_CMP: begin
          if (greater) begin
            pos <= pos_dec;
            if (!(pos_dec > rp)) begin
              state <= ST_INS_PUT;             // walk reached the read position
            end
          end else begin
            count <= cnt_inc;
            state <= ST_IDLE;
          end
        end
        ST_INS_PUT: begin
          count <= cnt_inc;
          state <= ST_IDLE;
        end
        ST_DRN_OUT: begin
          // hold until the output register can take the beat
          if (out_free) begin
            out_valid        <= 1'b1;
            valid_res        <= hit;
            sorted_id        <= hit ? rd_rec.id  : '0;
            sorted_time      <= hit ? rd_rec.tod : '0;
            sorted_direction <= hit ? rd_rec.dir : 1'b0;
            last_record      <= hit && (rp_inc == count);
            overflow         <= ovf_seen;
            if (hit) begin
              if (rp_inc == count) begin
                // final record out: store is empty again
                count    <= '0;
                rp       <= '0;
                ovf_seen <= 1'b0;
              end else begin
                rp <= rp_inc;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `RSIT_ASSERT_NOW(a_rp_le_count, 1'b1, rp <= count, "read position passed record count")
  `RSIT_ASSERT_NOW(a_walk_above_rp, state == ST_INS_CMP, pos > rp, "walk crossed read position")
  `RSIT_ASSERT_NEXT(a_put_grows, state == ST_INS_PUT, count == $past(cnt_inc), "store did not grow")

endmodule

`default_nettype wire
